// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue and its cell row.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY  = 64;
  localparam int TAG_BITS  = 16;
  localparam int PRIO_BITS = 16;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_POP     = 2'd1,
    OP_UPGRADE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SHIFT  = 2'd2,
    CMD_MATCH  = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t            cmd;
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_REMOVE = 2'd1,
    S_INSERT = 2'd2,
    S_REPORT = 2'd3
  } state_t;

endpackage

// ===== hw/rtl/sorted_priority_queue.sv =====
// Insert, pop and clear go from idle straight to the report state; upgrade
// matches in idle, then passes the remove and reinsert states before reporting,
// and skips the reinsert when no entry matches. A new request is taken only in
// the idle state, so one transaction reaches its report before the next starts.
// Reset clears the entry count, control state and the response valid; the
// slot contents are left as they are and only slots below the count are used.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded min-first priority queue, stable among equal priorities, built as
// a row of shifting cells kept in ascending priority order.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    op,
  input  logic [spq_pkg::TAG_BITS-1:0]  tag,
  input  logic [spq_pkg::PRIO_BITS-1:0] prio,
  input  logic [spq_pkg::PRIO_BITS-1:0] new_prio,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [1:0]                    status,
  output logic [spq_pkg::TAG_BITS-1:0]  out_tag,
  output logic [spq_pkg::PRIO_BITS-1:0] out_prio,
  output logic [spq_pkg::TAG_BITS-1:0]  head_tag,
  output logic [spq_pkg::PRIO_BITS-1:0] head_prio,
  output logic                          is_empty,
  output logic [spq_pkg::CNT_BITS-1:0]  fill
);

  localparam int CAP = spq_pkg::CAPACITY;

  spq_pkg::state_t                state, state_next;
  logic [spq_pkg::CNT_BITS-1:0]   count, count_next;
  spq_pkg::status_t               op_status, op_status_next;
  logic [spq_pkg::TAG_BITS-1:0]   pop_tag, pop_tag_next;
  logic [spq_pkg::PRIO_BITS-1:0]  pop_prio, pop_prio_next;
  logic [spq_pkg::TAG_BITS-1:0]   upg_tag;
  logic [spq_pkg::PRIO_BITS-1:0]  upg_prio;
  spq_pkg::cell_ctl_t             ctl;
  logic                           req_accept;
  logic                           rsp_load;

  logic [spq_pkg::TAG_BITS-1:0]   cell_tag  [CAP];
  logic [spq_pkg::PRIO_BITS-1:0]  cell_prio [CAP];
  logic [CAP-1:0]                 cell_vld;
  logic [CAP-1:0]                 cell_ge;
  logic [CAP-1:0]                 cell_match;
  logic [CAP-1:0]                 take_right;
  logic [CAP-1:0]                 first_seen;

  assign req_stall  = (state != spq_pkg::S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign rsp_load   = (state == spq_pkg::S_REPORT) && (!rsp_valid || !rsp_stall);

  // cumulative match: every slot from the first match on closes the gap
  always_comb begin
    first_seen[0] = cell_match[0];
    for (int i = 1; i < CAP; i++) begin
      first_seen[i] = first_seen[i-1] | cell_match[i];
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAP; g++) begin : g_cell
      logic                          lge;
      logic [spq_pkg::TAG_BITS-1:0]  ltag, rtag;
      logic [spq_pkg::PRIO_BITS-1:0] lprio, rprio;

      assign cell_vld[g] = (spq_pkg::CNT_BITS'(g) < count);

      if (g == 0) begin : g_first
        assign lge   = 1'b0;
        assign ltag  = '0;
        assign lprio = '0;
      end else begin : g_mid
        assign lge   = cell_ge[g-1];
        assign ltag  = cell_tag[g-1];
        assign lprio = cell_prio[g-1];
      end

      if (g == CAP - 1) begin : g_last
        assign rtag  = '0;
        assign rprio = '0;
      end else begin : g_inner
        assign rtag  = cell_tag[g+1];
        assign rprio = cell_prio[g+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .vld        (cell_vld[g]),
        .left_ge    (lge),
        .left_tag   (ltag),
        .left_prio  (lprio),
        .right_tag  (rtag),
        .right_prio (rprio),
        .take_right (take_right[g]),
        .tag        (cell_tag[g]),
        .prio       (cell_prio[g]),
        .ge         (cell_ge[g]),
        .match      (cell_match[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    op_status <= op_status_next;
    pop_tag   <= pop_tag_next;
    pop_prio  <= pop_prio_next;
    if (req_accept) begin
      upg_tag  <= tag;
      upg_prio <= new_prio;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    op_status_next = op_status;
    pop_tag_next   = pop_tag;
    pop_prio_next  = pop_prio;
    ctl.cmd        = spq_pkg::CMD_HOLD;
    ctl.tag        = tag;
    ctl.prio       = prio;
    take_right     = '0;
    case (state)
      spq_pkg::S_IDLE: begin
        if (req_accept) begin
          op_status_next = spq_pkg::ST_OK;
          pop_tag_next   = '0;
          pop_prio_next  = '0;
          state_next     = spq_pkg::S_REPORT;
          case (spq_pkg::op_t'(op))
            spq_pkg::OP_INSERT: begin
              if (count == spq_pkg::CNT_BITS'(CAP)) begin
                op_status_next = spq_pkg::ST_FULL;
              end else begin
                ctl.cmd    = spq_pkg::CMD_INSERT;
                count_next = count + 1'b1;
              end
            end
            spq_pkg::OP_POP: begin
              if (count == '0) begin
                op_status_next = spq_pkg::ST_EMPTY;
              end else begin
                pop_tag_next  = cell_tag[0];
                pop_prio_next = cell_prio[0];
                ctl.cmd       = spq_pkg::CMD_SHIFT;
                take_right    = '1;
                count_next    = count - 1'b1;
              end
            end
            spq_pkg::OP_UPGRADE: begin
              ctl.cmd    = spq_pkg::CMD_MATCH;
              state_next = spq_pkg::S_REMOVE;
            end
            default: begin
              count_next = '0;
            end
          endcase
        end
      end
      spq_pkg::S_REMOVE: begin
        if (first_seen[CAP-1]) begin
          ctl.cmd    = spq_pkg::CMD_SHIFT;
          take_right = first_seen;
          count_next = count - 1'b1;
          state_next = spq_pkg::S_INSERT;
        end else begin
          op_status_next = spq_pkg::ST_NOT_FOUND;
          state_next     = spq_pkg::S_REPORT;
        end
      end
      spq_pkg::S_INSERT: begin
        ctl.cmd    = spq_pkg::CMD_INSERT;
        ctl.tag    = upg_tag;
        ctl.prio   = upg_prio;
        count_next = count + 1'b1;
        state_next = spq_pkg::S_REPORT;
      end
      spq_pkg::S_REPORT: begin
        if (rsp_load) begin
          state_next = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = spq_pkg::S_IDLE;
      end
    endcase
  end

  // response register: a finished transaction waits here while the next one runs
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      status    <= op_status;
      out_tag   <= pop_tag;
      out_prio  <= pop_prio;
      head_tag  <= (count != '0) ? cell_tag[0] : '0;
      head_prio <= (count != '0) ? cell_prio[0] : '0;
      is_empty  <= (count == '0);
      fill      <= count;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_BITS'(CAP))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    req_accept && (op == spq_pkg::OP_INSERT) && (count != spq_pkg::CNT_BITS'(CAP))
    |=> count == $past(count) + 1'b1)
    else $error("insert did not add an entry");

  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> (fill == '0) && (head_tag == '0) && (head_prio == '0))
    else $error("empty response carries a head entry");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == spq_pkg::ST_EMPTY) |-> is_empty && (out_tag == '0))
    else $error("empty status on a nonempty queue");

  a_upgrade_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (state == spq_pkg::S_INSERT) |=> count == $past(count) + 1'b1)
    else $error("upgrade changed the entry count");

endmodule

// ===== hw/rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds a tag and priority, takes the new entry
// or its left neighbor on insert, its right neighbor on removal, and flags a match on lookup.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                          clk,
  input  spq_pkg::cell_ctl_t            ctl,
  input  logic                          vld,
  input  logic                          left_ge,
  input  logic [spq_pkg::TAG_BITS-1:0]  left_tag,
  input  logic [spq_pkg::PRIO_BITS-1:0] left_prio,
  input  logic [spq_pkg::TAG_BITS-1:0]  right_tag,
  input  logic [spq_pkg::PRIO_BITS-1:0] right_prio,
  input  logic                          take_right,
  output logic [spq_pkg::TAG_BITS-1:0]  tag,
  output logic [spq_pkg::PRIO_BITS-1:0] prio,
  output logic                          ge,
  output logic                          match
);

  // empty slots and strictly larger priorities sit behind the new entry
  always_comb begin
    ge = !vld || (prio > ctl.prio);
  end

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      spq_pkg::CMD_INSERT: begin
        if (ge) begin
          if (left_ge) begin
            tag  <= left_tag;
            prio <= left_prio;
          end else begin
            tag  <= ctl.tag;
            prio <= ctl.prio;
          end
        end
      end
      spq_pkg::CMD_SHIFT: begin
        if (take_right) begin
          tag  <= right_tag;
          prio <= right_prio;
        end
      end
      spq_pkg::CMD_MATCH: begin
        match <= vld && (tag == ctl.tag) && (prio == ctl.prio);
      end
      default: begin
      end
    endcase
  end

endmodule
